FILE: src/sart_pkg.sv
// Shared types and constants for the sorted address range table.
// No dependencies.
`timescale 1ns / 1ps

package sart_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_WRITABLE = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_DUP      = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_ZERO     = 3'd5;

  localparam logic [1:0] REG_EXTRA = 2'd0;
  localparam logic [1:0] REG_PAGE  = 2'd1;
  localparam logic [1:0] REG_DEFAULT = 2'd2;

  localparam int PTR_SHIFT = 3;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_SCAN, S_SCAN_WAIT, S_SHIFT_RD, S_SHIFT_WR, S_PUT,
    S_RM_SCAN, S_RM_WAIT, S_RM_RD, S_RM_WR, S_LK_RD, S_LK_WAIT, S_CLR_RD,
    S_CLR_WR, S_OUT
  } state_t;

  typedef struct packed {
    logic        we;
    logic [63:0] start;
    logic [63:0] stop;
    logic [31:0] owner;
    logic        writable;
    logic        fresh;
  } slot_wr_t;

endpackage

FILE: src/sart_divider.sv
// Restoring divider, one quotient bit per cycle: 32-bit dividend by 8-bit divisor.
// Uses no package.
`timescale 1ns / 1ps

module sart_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [7:0]  divisor,
  output logic        busy,
  output logic [31:0] quotient
);
  logic [8:0]  rem;
  logic [7:0]  dvs;
  logic [5:0]  cnt;
  logic [9:0]  trial;

  assign trial = {rem, quotient[31]} - {2'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      cnt      <= 6'd32;
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      if (!trial[9]) begin
        rem <= trial[8:0];
      end else begin
        rem <= {rem[7:0], quotient[31]};
      end
      quotient <= {quotient[30:0], !trial[9]};
      cnt      <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
      end
    end
  end
endmodule

FILE: src/sart_slot_ram.sv
// Slot memory: one write port, one registered read port.
// Depends on sart_pkg.
`timescale 1ns / 1ps

module sart_slot_ram #(
  parameter int DEPTH = 32,
  parameter int OWNER_BITS = 16
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  sart_pkg::slot_wr_t       wr,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output sart_pkg::slot_wr_t       rd
);
  localparam int W = 64 + 64 + OWNER_BITS + 2;
  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] q;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr_addr] <= {wr.start, wr.stop, wr.owner[OWNER_BITS-1:0], wr.writable, wr.fresh};
    end
    q <= mem[rd_addr];
  end

  always_comb begin
    rd.we       = 1'b0;
    rd.start    = q[W-1 -: 64];
    rd.stop     = q[W-65 -: 64];
    rd.owner    = 32'(q[OWNER_BITS+1:2]);
    rd.writable = q[1];
    rd.fresh    = q[0];
  end
endmodule

FILE: src/sorted_address_range_table_unit.sv
// Top level of the sorted address range table; control sequencer over the slot memory.
// Depends on sart_pkg, sart_slot_ram and sart_divider.
`timescale 1ns / 1ps

// Sorted table of address regions held in one synchronous slot memory. One item is worked
// at a time and gives exactly one result item. Insert first divides for the relocation
// count, then scans slots and shifts the later slots up; remove scans slots and moves the
// later slots down; lookup runs a binary search over the used slots and then reads the
// slot found; clear-new walks every used slot. Every step reads through the single
// registered read port of the memory.
module sorted_address_range_table_unit #(
  parameter int TABLE_DEPTH = 32,
  parameter int OWNER_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [63:0] address,
  input  logic [31:0] reloc_bytes,
  input  logic [7:0]  reloc_entry_bytes,
  input  logic [15:0] owner_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [4:0]  entry_index,
  output logic [63:0] region_start,
  output logic [63:0] region_end,
  output logic [63:0] protect_start,
  output logic [63:0] protect_length,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  sart_pkg::state_t state, state_next;

  logic [3:0]  extra_slots;
  logic [4:0]  page_shift;
  logic [7:0]  default_entry_bytes;
  logic [CW-1:0] used_count;

  logic [1:0]  cmd;
  logic [63:0] addr;
  logic [OWNER_BITS-1:0] who;
  logic [63:0] new_end;
  logic [CW-1:0] pos, lo, hi, ptr;
  logic [CW-1:0] pos_next, lo_next, hi_next, ptr_next, used_next;
  logic [63:0] held_start, held_end;
  logic [63:0] held_start_next, held_end_next;

  logic [AW-1:0] rd_addr, wr_addr;
  sart_pkg::slot_wr_t wr, rd;

  logic        div_start, div_busy;
  logic [31:0] div_q;
  logic [7:0]  divisor;

  logic [2:0]  o_status, o_status_next;
  logic [CW-1:0] o_idx, o_idx_next;
  logic [63:0] o_ps, o_ps_next, o_pl, o_pl_next;
  logic        div_wait, div_wait_next;

  logic [CW-1:0] mid;
  logic [64:0] end_sum;
  logic [63:0] page_mask;

  sart_slot_ram #(.DEPTH(TABLE_DEPTH), .OWNER_BITS(OWNER_BITS)) u_ram (
    .clk(clk), .wr_addr(wr_addr), .wr(wr), .rd_addr(rd_addr), .rd(rd)
  );

  always_comb begin
    if (reloc_entry_bytes != 8'd0) divisor = reloc_entry_bytes;
    else if (default_entry_bytes != 8'd0) divisor = default_entry_bytes;
    else divisor = 8'd1;
  end

  sart_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(reloc_bytes),
    .divisor(divisor), .busy(div_busy), .quotient(div_q)
  );

  assign end_sum = {1'b0, addr} +
                   {29'd0, ({1'b0, div_q} + 33'(extra_slots) + 33'd1), 3'd0};
  assign mid = lo + ((hi - lo) >> 1);
  assign page_mask = ~((64'd1 << page_shift) - 64'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      extra_slots <= 4'd3;
      page_shift <= 5'd12;
      default_entry_bytes <= 8'd24;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sart_pkg::REG_EXTRA:   extra_slots <= cfg_data[3:0];
        sart_pkg::REG_PAGE:    page_shift <= cfg_data[4:0];
        sart_pkg::REG_DEFAULT: default_entry_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sart_pkg::S_IDLE;
      used_count <= '0;
    end else begin
      state <= state_next;
      used_count <= used_next;
    end
    if (state == sart_pkg::S_IDLE && in_valid) begin
      cmd <= command;
      addr <= address;
      who <= OWNER_BITS'(owner_id);
    end
    if (state == sart_pkg::S_DIV && !div_busy && !div_wait) begin
      new_end <= end_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : end_sum[63:0];
    end
    pos <= pos_next;
    lo <= lo_next;
    hi <= hi_next;
    ptr <= ptr_next;
    held_start <= held_start_next;
    held_end <= held_end_next;
    o_status <= o_status_next;
    o_idx <= o_idx_next;
    o_ps <= o_ps_next;
    o_pl <= o_pl_next;
    div_wait <= div_wait_next;
  end

  always_comb begin
    state_next = state;
    used_next = used_count;
    pos_next = pos;
    lo_next = lo;
    hi_next = hi;
    ptr_next = ptr;
    held_start_next = held_start;
    held_end_next = held_end;
    o_status_next = o_status;
    o_idx_next = o_idx;
    o_ps_next = o_ps;
    o_pl_next = o_pl;
    div_wait_next = 1'b0;
    div_start = 1'b0;
    rd_addr = ptr[AW-1:0];
    wr_addr = ptr[AW-1:0];
    wr = rd;
    wr.we = 1'b0;
    in_stall = (state != sart_pkg::S_IDLE);
    out_valid = (state == sart_pkg::S_OUT);

    unique case (state)
      sart_pkg::S_IDLE: begin
        if (in_valid) begin
          o_status_next = sart_pkg::ST_DONE;
          o_idx_next = '0;
          o_ps_next = '0;
          o_pl_next = '0;
          held_start_next = '0;
          held_end_next = '0;
          ptr_next = '0;
          unique case (command)
            sart_pkg::CMD_INSERT: begin
              if (address == 64'd0) begin
                o_status_next = sart_pkg::ST_ZERO;
                state_next = sart_pkg::S_OUT;
              end else if (used_count >= CW'(TABLE_DEPTH)) begin
                o_status_next = sart_pkg::ST_FULL;
                state_next = sart_pkg::S_OUT;
              end else begin
                div_start = 1'b1;
                div_wait_next = 1'b1;
                state_next = sart_pkg::S_DIV;
              end
            end
            sart_pkg::CMD_REMOVE: state_next = sart_pkg::S_RM_SCAN;
            sart_pkg::CMD_LOOKUP: begin
              lo_next = '0;
              hi_next = used_count;
              state_next = sart_pkg::S_LK_RD;
            end
            default: state_next = sart_pkg::S_CLR_RD;
          endcase
        end
      end
      sart_pkg::S_DIV: begin
        if (!div_busy && !div_wait) state_next = sart_pkg::S_SCAN;
      end
      sart_pkg::S_SCAN: begin
        if (ptr >= used_count) begin
          pos_next = ptr;
          ptr_next = used_count;
          state_next = sart_pkg::S_SHIFT_RD;
        end else begin
          state_next = sart_pkg::S_SCAN_WAIT;
        end
      end
      sart_pkg::S_SCAN_WAIT: begin
        if (rd.start < addr) begin
          ptr_next = ptr + 1'b1;
          state_next = sart_pkg::S_SCAN;
        end else if (rd.start == addr) begin
          o_status_next = sart_pkg::ST_DUP;
          o_idx_next = ptr;
          held_start_next = rd.start;
          held_end_next = rd.stop;
          state_next = sart_pkg::S_OUT;
        end else begin
          pos_next = ptr;
          ptr_next = used_count;
          state_next = sart_pkg::S_SHIFT_RD;
        end
      end
      sart_pkg::S_SHIFT_RD: begin
        rd_addr = AW'(ptr - 1'b1);
        if (ptr == pos) state_next = sart_pkg::S_PUT;
        else state_next = sart_pkg::S_SHIFT_WR;
      end
      sart_pkg::S_SHIFT_WR: begin
        wr.we = 1'b1;
        ptr_next = ptr - 1'b1;
        state_next = sart_pkg::S_SHIFT_RD;
      end
      sart_pkg::S_PUT: begin
        wr.we = 1'b1;
        wr.start = addr;
        wr.stop = new_end;
        wr.owner = 32'(who);
        wr.writable = 1'b0;
        wr.fresh = 1'b1;
        used_next = used_count + 1'b1;
        o_idx_next = pos;
        held_start_next = addr;
        held_end_next = new_end;
        state_next = sart_pkg::S_OUT;
      end
      sart_pkg::S_RM_SCAN: begin
        if (ptr >= used_count) begin
          o_status_next = sart_pkg::ST_NOTFOUND;
          state_next = sart_pkg::S_OUT;
        end else begin
          state_next = sart_pkg::S_RM_WAIT;
        end
      end
      sart_pkg::S_RM_WAIT: begin
        if (rd.owner[OWNER_BITS-1:0] == who) begin
          o_idx_next = ptr;
          held_start_next = rd.start;
          held_end_next = rd.stop;
          state_next = sart_pkg::S_RM_RD;
        end else begin
          ptr_next = ptr + 1'b1;
          state_next = sart_pkg::S_RM_SCAN;
        end
      end
      sart_pkg::S_RM_RD: begin
        rd_addr = AW'(ptr + 1'b1);
        if (CW'(ptr + 1'b1) >= used_count) begin
          used_next = used_count - 1'b1;
          state_next = sart_pkg::S_OUT;
        end else begin
          state_next = sart_pkg::S_RM_WR;
        end
      end
      sart_pkg::S_RM_WR: begin
        wr.we = 1'b1;
        ptr_next = ptr + 1'b1;
        state_next = sart_pkg::S_RM_RD;
      end
      sart_pkg::S_LK_RD: begin
        if (lo < hi) begin
          rd_addr = mid[AW-1:0];
          ptr_next = mid;
          state_next = sart_pkg::S_LK_WAIT;
        end else if (lo == '0) begin
          o_status_next = sart_pkg::ST_NOTFOUND;
          state_next = sart_pkg::S_OUT;
        end else begin
          rd_addr = AW'(lo - 1'b1);
          ptr_next = lo - 1'b1;
          hi_next = '0;
          lo_next = '0;
          state_next = sart_pkg::S_CLR_WR;
        end
      end
      sart_pkg::S_LK_WAIT: begin
        if (rd.start <= addr) lo_next = ptr + 1'b1;
        else hi_next = ptr;
        state_next = sart_pkg::S_LK_RD;
      end
      sart_pkg::S_CLR_RD: begin
        if (ptr >= used_count) state_next = sart_pkg::S_OUT;
        else state_next = sart_pkg::S_CLR_WR;
      end
      sart_pkg::S_CLR_WR: begin
        if (cmd == sart_pkg::CMD_CLEAR) begin
          if (rd.fresh) begin
            wr.we = 1'b1;
            wr.fresh = 1'b0;
            wr.writable = 1'b0;
          end
          ptr_next = ptr + 1'b1;
          state_next = sart_pkg::S_CLR_RD;
        end else begin
          if (addr >= rd.stop) begin
            o_status_next = sart_pkg::ST_NOTFOUND;
          end else begin
            o_idx_next = ptr;
            held_start_next = rd.start;
            held_end_next = rd.stop;
            if (rd.writable) begin
              o_status_next = sart_pkg::ST_WRITABLE;
            end else begin
              wr.we = 1'b1;
              wr.writable = 1'b1;
              o_ps_next = rd.start & page_mask;
              o_pl_next = rd.stop - (rd.start & page_mask);
            end
          end
          state_next = sart_pkg::S_OUT;
        end
      end
      sart_pkg::S_OUT: begin
        if (!out_stall) state_next = sart_pkg::S_IDLE;
      end
      default: state_next = sart_pkg::S_IDLE;
    endcase
  end

  assign status = o_status;
  assign entry_index = 5'(o_idx);
  assign region_start = held_start;
  assign region_end = held_end;
  assign protect_start = o_ps;
  assign protect_length = o_pl;
endmodule

FILE: tb/sorted_address_range_table_unit_tb.sv
// Self-checking bench for the sorted address range table: a behavioural copy of the table
// predicts each result item, which is checked against the block's output in order.
// Depends on sart_pkg and sorted_address_range_table_unit.
`timescale 1ns / 1ps

module sorted_address_range_table_unit_tb;

  localparam int DEPTH = 32;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  entry_index;
    logic [63:0] region_start;
    logic [63:0] region_end;
    logic [63:0] protect_start;
    logic [63:0] protect_length;
  } range_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  command = sart_pkg::CMD_CLEAR;
  logic [63:0] address = '0;
  logic [31:0] reloc_bytes = '0;
  logic [7:0]  reloc_entry_bytes = '0;
  logic [15:0] owner_id = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [4:0]  entry_index;
  logic [63:0] region_start;
  logic [63:0] region_end;
  logic [63:0] protect_start;
  logic [63:0] protect_length;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = sart_pkg::REG_EXTRA;
  logic [7:0]  cfg_data = '0;

  sorted_address_range_table_unit i_dut (.*);

  // predicted table state
  logic [63:0] tbl_start [DEPTH];
  logic [63:0] tbl_end [DEPTH];
  logic [15:0] tbl_owner [DEPTH];
  logic        tbl_writable [DEPTH];
  logic        tbl_fresh [DEPTH];
  int          tbl_used = 0;
  logic [3:0]  cur_extra = 4'd3;
  logic [4:0]  cur_page = 5'd12;
  logic [7:0]  cur_default = 8'd24;

  range_result_t expected_q[$];
  int  mismatches = 0;
  int  results_seen = 0;
  int  items_sent = 0;
  int  idle_cycles = 0;
  int  stall_left = 0;
  bit  quiet = 1'b0;
  bit  timed_out = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void copy_slot(int to, int from);
    tbl_start[to] = tbl_start[from];
    tbl_end[to] = tbl_end[from];
    tbl_owner[to] = tbl_owner[from];
    tbl_writable[to] = tbl_writable[from];
    tbl_fresh[to] = tbl_fresh[from];
  endfunction

  function automatic range_result_t predict_range_op(logic [1:0] cmd, logic [63:0] addr,
                                                     logic [31:0] rb, logic [7:0] eb,
                                                     logic [15:0] own);
    range_result_t r;
    logic [63:0] ebytes, size, pstart;
    logic [64:0] sum;
    int pos, lo, hi, mid, k;
    r = '0;
    case (cmd)
      sart_pkg::CMD_INSERT: begin
        if (addr == 0) begin
          r.status = sart_pkg::ST_ZERO;
        end else if (tbl_used >= DEPTH) begin
          r.status = sart_pkg::ST_FULL;
        end else begin
          ebytes = (eb != 0) ? 64'(eb) : 64'(cur_default);
          if (ebytes == 0) ebytes = 1;
          size = ((64'(rb) / ebytes) + 64'(cur_extra) + 64'd1) * 64'd8;
          sum = {1'b0, addr} + {1'b0, size};
          pos = 0;
          while (pos < tbl_used && tbl_start[pos] < addr) pos++;
          if (pos < tbl_used && tbl_start[pos] == addr) begin
            r.status = sart_pkg::ST_DUP;
            r.entry_index = 5'(pos);
            r.region_start = tbl_start[pos];
            r.region_end = tbl_end[pos];
          end else begin
            for (int i = tbl_used; i > pos; i--) copy_slot(i, i - 1);
            tbl_start[pos] = addr;
            tbl_end[pos] = sum[64] ? '1 : sum[63:0];
            tbl_owner[pos] = own;
            tbl_writable[pos] = 1'b0;
            tbl_fresh[pos] = 1'b1;
            tbl_used++;
            r.status = sart_pkg::ST_DONE;
            r.entry_index = 5'(pos);
            r.region_start = addr;
            r.region_end = tbl_end[pos];
          end
        end
      end
      sart_pkg::CMD_REMOVE: begin
        pos = 0;
        while (pos < tbl_used && tbl_owner[pos] != own) pos++;
        if (pos >= tbl_used) begin
          r.status = sart_pkg::ST_NOTFOUND;
        end else begin
          r.status = sart_pkg::ST_DONE;
          r.entry_index = 5'(pos);
          r.region_start = tbl_start[pos];
          r.region_end = tbl_end[pos];
          for (int i = pos; i + 1 < tbl_used; i++) copy_slot(i, i + 1);
          tbl_used--;
        end
      end
      sart_pkg::CMD_LOOKUP: begin
        lo = 0;
        hi = tbl_used;
        while (lo < hi) begin
          mid = lo + (hi - lo) / 2;
          if (tbl_start[mid] <= addr) lo = mid + 1;
          else hi = mid;
        end
        k = lo - 1;
        if (lo == 0 || addr >= tbl_end[k]) begin
          r.status = sart_pkg::ST_NOTFOUND;
        end else begin
          r.entry_index = 5'(k);
          r.region_start = tbl_start[k];
          r.region_end = tbl_end[k];
          if (tbl_writable[k]) begin
            r.status = sart_pkg::ST_WRITABLE;
          end else begin
            pstart = tbl_start[k] & ~((64'd1 << cur_page) - 64'd1);
            tbl_writable[k] = 1'b1;
            r.status = sart_pkg::ST_DONE;
            r.protect_start = pstart;
            r.protect_length = tbl_end[k] - pstart;
          end
        end
      end
      default: begin
        for (int i = 0; i < tbl_used; i++) begin
          if (tbl_fresh[i]) begin
            tbl_fresh[i] = 1'b0;
            tbl_writable[i] = 1'b0;
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic random_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic send_item(logic [1:0] cmd, logic [63:0] addr, logic [31:0] rb,
                           logic [7:0] eb, logic [15:0] own);
    random_gap();
    in_valid <= 1'b1;
    command <= cmd;
    address <= addr;
    reloc_bytes <= rb;
    reloc_entry_bytes <= eb;
    owner_id <= own;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.push_back(predict_range_op(cmd, addr, rb, eb, own));
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      sart_pkg::REG_EXTRA: cur_extra = val[3:0];
      sart_pkg::REG_PAGE: cur_page = val[4:0];
      default: cur_default = val;
    endcase
  endtask

  task automatic set_config(logic [3:0] ex, logic [4:0] pg, logic [7:0] df);
    write_reg(sart_pkg::REG_EXTRA, 8'(ex));
    write_reg(sart_pkg::REG_PAGE, 8'(pg));
    write_reg(sart_pkg::REG_DEFAULT, df);
  endtask

  task automatic empty_table();
    while (tbl_used > 0) send_item(sart_pkg::CMD_REMOVE, '0, '0, '0, tbl_owner[0]);
  endtask

  task automatic test_directed();
    send_item(sart_pkg::CMD_LOOKUP, 64'h1000, '0, '0, '0);
    send_item(sart_pkg::CMD_REMOVE, '0, '0, '0, 16'h1);
    send_item(sart_pkg::CMD_INSERT, '0, 32'd100, 8'd8, 16'h1);
    send_item(sart_pkg::CMD_INSERT, 64'h4000, 32'd240, 8'd0, 16'h1);
    send_item(sart_pkg::CMD_INSERT, 64'h2000, '1, 8'd255, 16'hFFFF);
    send_item(sart_pkg::CMD_INSERT, 64'h4000, 32'd8, 8'd8, 16'h2);
    send_item(sart_pkg::CMD_INSERT, '1, '1, 8'd1, 16'h3);
    send_item(sart_pkg::CMD_LOOKUP, 64'h4008, '0, '0, '0);
    send_item(sart_pkg::CMD_LOOKUP, 64'h4010, '0, '0, '0);
    send_item(sart_pkg::CMD_LOOKUP, 64'h1FFF, '0, '0, '0);
    send_item(sart_pkg::CMD_LOOKUP, '1, '0, '0, '0);
    send_item(sart_pkg::CMD_CLEAR, '0, '0, '0, '0);
    send_item(sart_pkg::CMD_LOOKUP, 64'h4000, '0, '0, '0);
    send_item(sart_pkg::CMD_REMOVE, '0, '0, '0, 16'hFFFF);
    send_item(sart_pkg::CMD_REMOVE, '0, '0, '0, 16'h1);
    send_item(sart_pkg::CMD_REMOVE, '0, '0, '0, 16'h7);
    empty_table();
  endtask

  task automatic test_zero_divisor();
    set_config(4'd15, 5'd21, 8'd0);
    send_item(sart_pkg::CMD_INSERT, 64'h0123_4567_89AB_CDEF, 32'd77, 8'd0, 16'h5);
    send_item(sart_pkg::CMD_INSERT, 64'hFFFF_FFFF_FFFF_FF00, '1, 8'd0, 16'h6);
    send_item(sart_pkg::CMD_LOOKUP, 64'h0123_4567_89AB_CDF0, '0, '0, '0);
    empty_table();
  endtask

  task automatic test_full_table();
    for (int i = 0; i < DEPTH + 2; i++)
      send_item(sart_pkg::CMD_INSERT, 64'(DEPTH - i) << 16, 32'(i), 8'd1, 16'(i));
    for (int i = 0; i < DEPTH; i++)
      send_item(sart_pkg::CMD_LOOKUP, (64'(i + 1) << 16) + 64'd3, '0, '0, '0);
    // pause the sender until everything is back
    wait_drained();
    empty_table();
  endtask

  task automatic test_odd_page();
    set_config(4'd0, 5'd31, 8'd1);
    send_item(sart_pkg::CMD_INSERT, 64'hDEAD_BEEF_1234_5678, 32'd16, 8'd0, 16'h9);
    send_item(sart_pkg::CMD_LOOKUP, 64'hDEAD_BEEF_1234_5678, '0, '0, '0);
    set_config(4'd7, 5'd0, 8'd255);
    send_item(sart_pkg::CMD_INSERT, 64'hDEAD_BEEF_0000_0001, 32'd16, 8'd0, 16'h9);
    send_item(sart_pkg::CMD_LOOKUP, 64'hDEAD_BEEF_0000_0001, '0, '0, '0);
    empty_table();
  endtask

  task automatic test_random(int count);
    logic [63:0] addr;
    logic [1:0]  cmd;
    int          pick;
    for (int n = 0; n < count; n++) begin
      if (n == count - 200) quiet = 1'b1;
      pick = $urandom_range(0, 99);
      cmd = pick < 45 ? sart_pkg::CMD_INSERT : pick < 65 ? sart_pkg::CMD_REMOVE :
            pick < 95 ? sart_pkg::CMD_LOOKUP : sart_pkg::CMD_CLEAR;
      addr = {$urandom(), $urandom()};
      if ($urandom_range(0, 2) != 0) addr = 64'($urandom_range(1, 64)) << 12;
      if (cmd == sart_pkg::CMD_LOOKUP && tbl_used > 0 && $urandom_range(0, 2) != 0)
        addr = tbl_start[$urandom_range(0, tbl_used - 1)] + 64'($urandom_range(0, 300));
      if ($urandom_range(0, 40) == 0) addr = '0;
      send_item(cmd, addr, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 2000),
                8'($urandom_range(0, 3) == 0 ? 0 : $urandom()), 16'($urandom_range(0, 15)) |
                ($urandom_range(0, 9) == 0 ? 16'($urandom()) : 16'h0));
      if (n % 300 == 299 && !quiet)
        set_config(4'($urandom()), 5'($urandom_range(12, 21)), 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_zero_divisor();
    test_full_table();
    test_odd_page();
    set_config(4'd3, 5'd12, 8'd24);
    test_random(1375);
    wait_drained();
    $display("%0d items sent and %0d results checked over insert, remove, lookup, clear-new,",
             items_sent, results_seen);
    $display("full table, duplicate and zero base cases, across several register settings");
    if (mismatches == 0 && !timed_out) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // result checker and receiver stall
  always @(posedge clk) begin
    range_result_t got, want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got = {status, entry_index, region_start, region_end, protect_start, protect_length};
        results_seen <= results_seen + 1;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item %p", got);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
          end
        end
      end
      if (quiet) begin
        out_stall <= 1'b0;
        stall_left <= 0;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(0, 6);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      timed_out = 1'b1;
      $display("simulation failed");
      $finish;
    end
  end

endmodule

FILE: sim.f
src/sart_pkg.sv
src/sart_divider.sv
src/sart_slot_ram.sv
src/sorted_address_range_table_unit.sv
tb/sorted_address_range_table_unit_tb.sv
